// ----- rtl/core/ntam_pkg.sv -----
// Shared constants, types and state codes of the thermistor array monitor.
package ntam_pkg;

   localparam int ADC_BITS_DEF  = 12;
   localparam int NUM_CELLS_DEF = 4;

   localparam int CH_MAX_W    = 5;
   localparam int ADC_MAX_W   = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int LOG_LANES  = 4;
   localparam int LOG_IN_W   = 20;
   localparam int LOG_FRAC_W = 24;
   localparam int LOG_EXP_W  = 5;
   localparam int LOG_OUT_W  = LOG_EXP_W + LOG_FRAC_W;
   localparam int MANT_W     = 31;

   localparam int DIV_NUM_W = 52;
   localparam int DIV_DEN_W = 48;

   localparam int L_W  = 32;
   localparam int P_W  = 64;
   localparam int S_W  = 50;
   localparam int Q_W  = 53;

   localparam int KR_W     = 22;
   localparam int RECIP_W  = 23;
   localparam int RECIP_SH = 29;

   localparam int TEMP_W     = 16;
   localparam int SPREAD_W   = 16;
   localparam int RATE_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int BETA_W     = 16;
   localparam int OHMS_W     = 20;
   localparam int T0_W       = 9;

   localparam logic signed [TEMP_W-1:0] SENTINEL_TEMP   = -16'sd15984;
   localparam logic signed [TEMP_W-1:0] PREV_RESET_TEMP = 16'sd400;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX        = 16'sh7fff;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN        = 16'sh8000;

   localparam logic signed [L_W-1:0]    LN2_Q30        = 32'sd744261118;
   localparam logic [DIV_NUM_W-1:0]     INV0_NUM       = 52'd100 << 40;
   localparam logic [DIV_NUM_W-1:0]     KELVIN_NUM     = 52'd1600 << 40;
   localparam logic [19:0]              KELVIN_OFFSET  = 20'd437040;
   localparam logic [Q_W-1:0]           HALF_HUNDRED   = 53'd50;
   localparam logic [Q_W-1:0]           KELVIN_SAT     = 53'd3276900;
   localparam logic [RECIP_W-1:0]       RECIP_100      = 23'd5368710;
   localparam logic signed [17:0]       ZERO_C_CENTI   = 18'sd27315;
   localparam logic signed [17:0]       CENTI_SCALE    = 18'sd100;

   localparam logic [BETA_W-1:0] BETA_RESET    = 16'd3950;
   localparam logic [OHMS_W-1:0] SERIES_RESET  = 20'd10000;
   localparam logic [OHMS_W-1:0] NOMINAL_RESET = 20'd10000;
   localparam logic [T0_W-1:0]   T0_RESET      = 9'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BETA         = 2'd0,
      CSR_SERIES       = 2'd1,
      CSR_NOMINAL_OHMS = 2'd2,
      CSR_NOMINAL_TEMP = 2'd3
   } ntam_csr_type;

   typedef enum logic [1:0] {
      KIND_CELL,
      KIND_AMBIENT,
      KIND_OTHER
   } ntam_kind_type;

   typedef struct packed {
      ntam_kind_type          kind;
      logic [CH_MAX_W-1:0]    channel;
      logic [ADC_MAX_W-1:0]   raw;
      logic                   fault;
   } ntam_item_type;

   typedef struct packed {
      logic [BETA_W-1:0] beta;
      logic [OHMS_W-1:0] series;
      logic [OHMS_W-1:0] nominal;
      logic [T0_W-1:0]   temp0;
   } ntam_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG,
      ST_SCALE,
      ST_TERM,
      ST_INV0,
      ST_SUM,
      ST_QUOT,
      ST_KELVIN,
      ST_ROUND,
      ST_STATS,
      ST_SWEEP,
      ST_DONE
   } ntam_state_type;

endpackage

// ----- rtl/core/ntam_front.sv -----
// Front end: accepts samples, classifies them and queues them for the converter.
module ntam_front #(
   parameter int ADC_BITS  = ntam_pkg::ADC_BITS_DEF,
   parameter int NUM_CELLS = ntam_pkg::NUM_CELLS_DEF,
   parameter int CH_W      = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CH_W-1:0]        req_channel,
   input  logic [ADC_BITS-1:0]    req_adc_sample,
   input  logic                   req_read_failed,
   output logic                   item_valid,
   output ntam_pkg::ntam_item_type item,
   input  logic                   item_pop
);
   import ntam_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADC_BITS-1:0] ADC_FULL = '1;

   ntam_item_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   ntam_item_type       classified;
   logic                push, pop;

   always_comb begin
      classified.channel = CH_MAX_W'(req_channel);
      classified.raw     = ADC_MAX_W'(req_adc_sample);
      classified.fault   = req_read_failed || (req_adc_sample == '0)
                           || (req_adc_sample == ADC_FULL);
      if (req_channel < CH_W'(NUM_CELLS)) begin
         classified.kind = KIND_CELL;
      end else if (req_channel == CH_W'(NUM_CELLS)) begin
         classified.kind = KIND_AMBIENT;
      end else begin
         classified.kind = KIND_OTHER;
      end
   end

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- rtl/core/ntam_log2.sv -----
// Four-lane base-2 logarithm in Q.24 by normalization and repeated squaring.
module ntam_log2 (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [ntam_pkg::LOG_LANES-1:0][ntam_pkg::LOG_IN_W-1:0]  x,
   output logic                                         done,
   output logic [ntam_pkg::LOG_LANES-1:0][ntam_pkg::LOG_OUT_W-1:0] result
);
   import ntam_pkg::*;

   localparam int CNT_W = $clog2(LOG_FRAC_W);

   function automatic logic [LOG_EXP_W-1:0] msb_index(input logic [LOG_IN_W-1:0] v);
      logic [LOG_EXP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
         if (v[i]) begin
            idx = LOG_EXP_W'(i);
         end
      end
      return idx;
   endfunction

   logic [MANT_W-1:0]     m_ff [LOG_LANES];
   logic [MANT_W-1:0]     m_in [LOG_LANES];
   logic [LOG_EXP_W-1:0]  e_ff [LOG_LANES];
   logic [LOG_EXP_W-1:0]  e_in [LOG_LANES];
   logic [LOG_FRAC_W-1:0] f_ff [LOG_LANES];
   logic [LOG_FRAC_W-1:0] f_in [LOG_LANES];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      logic [LOG_IN_W-1:0]   xs;
      logic [2*MANT_W-1:0]   sq;
      logic [MANT_W:0]       sq_sh;
      xs      = '0;
      sq      = '0;
      sq_sh   = '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      for (int k = 0; k < LOG_LANES; k++) begin
         m_in[k] = m_ff[k];
         e_in[k] = e_ff[k];
         f_in[k] = f_ff[k];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         for (int k = 0; k < LOG_LANES; k++) begin
            xs      = (x[k] == '0) ? LOG_IN_W'(1) : x[k];
            e_in[k] = msb_index(xs);
            m_in[k] = MANT_W'(MANT_W'(xs) << (MANT_W - 1 - 32'(e_in[k])));
            f_in[k] = '0;
         end
      end else if (busy_ff) begin
         // Each squaring yields one fraction bit; a square of two or more is renormalized.
         for (int k = 0; k < LOG_LANES; k++) begin
            sq      = m_ff[k] * m_ff[k];
            sq_sh   = sq[2*MANT_W-1:MANT_W-1];
            m_in[k] = sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
            f_in[k] = {f_ff[k][LOG_FRAC_W-2:0], sq_sh[MANT_W]};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(LOG_FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      for (int k = 0; k < LOG_LANES; k++) begin
         m_ff[k] <= m_in[k];
         e_ff[k] <= e_in[k];
         f_ff[k] <= f_in[k];
      end
   end

   always_comb begin
      for (int k = 0; k < LOG_LANES; k++) begin
         result[k] = {e_ff[k], f_ff[k]};
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/core/ntam_div.sv -----
// Shared restoring divider, one quotient bit per cycle, rounding to nearest.
module ntam_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ntam_pkg::DIV_NUM_W-1:0]  num,
   input  logic [ntam_pkg::DIV_DEN_W-1:0]  den,
   output logic                            done,
   output logic [ntam_pkg::DIV_NUM_W-1:0]  quot
);
   import ntam_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] work_ff, work_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   always_comb begin
      logic [DIV_DEN_W:0] trial;
      logic [DIV_DEN_W:0] diff;
      logic               fits;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, work_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      if (start) begin
         // Adding half the divisor turns the truncating quotient into a rounded one.
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W - 1);
         work_in = num + DIV_NUM_W'(den >> 1);
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         work_in = {work_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = CNT_W'(cnt_ff - 1'b1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = work_ff;

endmodule

// ----- rtl/core/ntam_back.sv -----
// Back end: converts queued samples to temperature, keeps frame statistics, holds the result.
module ntam_back #(
   parameter int ADC_BITS  = ntam_pkg::ADC_BITS_DEF,
   parameter int NUM_CELLS = ntam_pkg::NUM_CELLS_DEF,
   parameter int CH_W      = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ntam_pkg::ntam_cfg_type                cfg,
   input  logic                                  item_valid,
   input  ntam_pkg::ntam_item_type               item,
   output logic                                  item_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [CH_W-1:0]                       rsp_out_channel,
   output logic signed [ntam_pkg::TEMP_W-1:0]    rsp_temp_sixteenths,
   output logic                                  rsp_sensor_fault,
   output logic                                  rsp_frame_done,
   output logic signed [ntam_pkg::TEMP_W-1:0]    rsp_hottest_cell,
   output logic [ntam_pkg::SPREAD_W-1:0]         rsp_cell_spread,
   output logic [ntam_pkg::RATE_W-1:0]           rsp_max_rise_rate
);
   import ntam_pkg::*;

   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CELLS - 1);
   localparam logic [ADC_MAX_W-1:0] ADC_FULL = ADC_MAX_W'((1 << ADC_BITS) - 1);

   ntam_state_type state_ff, state_in;
   ntam_item_type  item_ff, item_in;
   logic           issued_ff, issued_in;

   logic signed [L_W-1:0]    l_ff, l_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [S_W-1:0]    term_ff, term_in;
   logic signed [S_W-1:0]    inv0_ff, inv0_in;
   logic signed [S_W-1:0]    s_ff, s_in;
   logic signed [Q_W-1:0]    q_ff, q_in;
   logic [KR_W-1:0]          kr_ff, kr_in;
   logic                     ksat_ff, ksat_in;
   logic                     kneg_ff, kneg_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                     fault_ff, fault_in;

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [TEMP_W-1:0] hot_ff, hot_in;
   logic signed [TEMP_W-1:0] cold_ff, cold_in;
   logic signed [17:0]       rate_ff, rate_in;
   logic signed [TEMP_W-1:0] frame_ff [NUM_CELLS];
   logic signed [TEMP_W-1:0] frame_in [NUM_CELLS];
   logic signed [TEMP_W-1:0] prev_ff [NUM_CELLS];
   logic signed [TEMP_W-1:0] prev_in [NUM_CELLS];
   logic                     first_ff, first_in;

   logic                     out_valid_ff, out_valid_in;
   logic [CH_W-1:0]          out_channel_ff, out_channel_in;
   logic signed [TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic                     out_fault_ff, out_fault_in;
   logic                     out_done_ff, out_done_in;
   logic signed [TEMP_W-1:0] out_hot_ff, out_hot_in;
   logic [SPREAD_W-1:0]      out_spread_ff, out_spread_in;
   logic [RATE_W-1:0]        out_rate_ff, out_rate_in;

   logic                                      log_start, log_done;
   logic [LOG_LANES-1:0][LOG_IN_W-1:0]        log_x;
   logic [LOG_LANES-1:0][LOG_OUT_W-1:0]       log_res;
   logic                                      div_start, div_done;
   logic [DIV_NUM_W-1:0]                      div_num, div_quot;
   logic [DIV_DEN_W-1:0]                      div_den;

   logic [P_W-1:0]           p_mag, ln_sum;
   logic [DIV_NUM_W-1:0]     term_num;
   logic [DIV_DEN_W-1:0]     beta_den;
   logic signed [17:0]       t0_ext, inv0_den_s;
   logic [S_W-1:0]           s_mag;
   logic signed [Q_W-1:0]    n2, n2_mag;
   logic [Q_W-1:0]           n2_rnd;
   logic [KR_W+RECIP_W-1:0]  k_prod;
   logic [TEMP_W-1:0]        k_quot;
   logic signed [S_W-1:0]    quot_s;
   logic signed [Q_W-1:0]    quot_q;

   always_comb begin
      log_x[0] = cfg.series;
      log_x[1] = LOG_IN_W'(item_ff.raw);
      log_x[2] = LOG_IN_W'(ADC_FULL - item_ff.raw);
      log_x[3] = cfg.nominal;
   end

   ntam_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   ntam_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Operand shaping for the three divisions and the final scaling.
   always_comb begin
      p_mag      = p_ff[P_W-1] ? P_W'(-p_ff) : P_W'(p_ff);
      ln_sum     = p_mag + (P_W'(1) << 29);
      term_num   = DIV_NUM_W'({ln_sum[61:30], 16'h0000});
      beta_den   = (cfg.beta == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(cfg.beta);
      t0_ext     = 18'($signed(cfg.temp0));
      inv0_den_s = t0_ext * CENTI_SCALE + ZERO_C_CENTI;
      s_mag      = s_ff[S_W-1] ? S_W'(-s_ff) : S_W'(s_ff);
      n2         = q_ff - $signed(Q_W'(KELVIN_OFFSET));
      n2_mag     = n2[Q_W-1] ? -n2 : n2;
      n2_rnd     = $unsigned(n2_mag) + HALF_HUNDRED;
      k_prod     = kr_ff * RECIP_100;
      k_quot     = k_prod[KR_W+RECIP_W-1:RECIP_SH];
      quot_s     = $signed(S_W'(div_quot));
      quot_q     = $signed(Q_W'(div_quot));
   end

   always_comb begin
      logic signed [TEMP_W-1:0] cur, pr;
      logic signed [17:0]       diff, r;
      logic                     load_out;

      state_in  = state_ff;
      item_in   = item_ff;
      issued_in = issued_ff;
      l_in      = l_ff;
      p_in      = p_ff;
      term_in   = term_ff;
      inv0_in   = inv0_ff;
      s_in      = s_ff;
      q_in      = q_ff;
      kr_in     = kr_ff;
      ksat_in   = ksat_ff;
      kneg_in   = kneg_ff;
      temp_in   = temp_ff;
      fault_in  = fault_ff;
      idx_in    = idx_ff;
      hot_in    = hot_ff;
      cold_in   = cold_ff;
      rate_in   = rate_ff;
      first_in  = first_ff;
      for (int i = 0; i < NUM_CELLS; i++) begin
         frame_in[i] = frame_ff[i];
         prev_in[i]  = prev_ff[i];
      end
      item_pop  = 1'b0;
      log_start = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      load_out  = 1'b0;

      cur    = frame_ff[idx_ff];
      pr     = prev_ff[idx_ff];
      diff   = 18'(cur) - 18'(pr);
      r      = diff <<< 1;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               if (item.fault) begin
                  temp_in  = SENTINEL_TEMP;
                  fault_in = 1'b1;
                  state_in = ST_STATS;
               end else begin
                  fault_in = 1'b0;
                  state_in = ST_LOG;
               end
            end
         end
         ST_LOG: begin
            log_start = !issued_ff;
            if (log_done) begin
               l_in = $signed(L_W'(log_res[0])) + $signed(L_W'(log_res[1]))
                      - $signed(L_W'(log_res[2])) - $signed(L_W'(log_res[3]));
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            p_in     = l_ff * LN2_Q30;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            div_start = !issued_ff;
            div_num   = term_num;
            div_den   = beta_den;
            if (div_done) begin
               term_in  = p_ff[P_W-1] ? -quot_s : quot_s;
               state_in = ST_INV0;
            end
         end
         ST_INV0: begin
            div_start = !issued_ff;
            div_num   = INV0_NUM;
            div_den   = DIV_DEN_W'($unsigned(inv0_den_s));
            if (div_done) begin
               inv0_in  = quot_s;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            s_in     = inv0_ff + term_ff;
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            if (s_ff == '0) begin
               temp_in  = TEMP_MAX;
               state_in = ST_STATS;
            end else begin
               div_start = !issued_ff;
               div_num   = KELVIN_NUM;
               div_den   = DIV_DEN_W'(s_mag);
               if (div_done) begin
                  q_in     = s_ff[S_W-1] ? -quot_q : quot_q;
                  state_in = ST_KELVIN;
               end
            end
         end
         ST_KELVIN: begin
            // Magnitudes beyond the 16-bit range saturate; the rest divide by a reciprocal.
            kr_in    = n2_rnd[KR_W-1:0];
            ksat_in  = (n2_rnd >= KELVIN_SAT);
            kneg_in  = n2[Q_W-1];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (ksat_ff) begin
               temp_in = kneg_ff ? TEMP_MIN : TEMP_MAX;
            end else if (kneg_ff) begin
               temp_in = -$signed(k_quot);
            end else if (k_quot[TEMP_W-1]) begin
               temp_in = TEMP_MAX;
            end else begin
               temp_in = $signed(k_quot);
            end
            state_in = ST_STATS;
         end
         ST_STATS: begin
            unique case (item_ff.kind)
               KIND_CELL: begin
                  frame_in[item_ff.channel[IDX_W-1:0]] = temp_ff;
                  state_in = ST_DONE;
               end
               KIND_AMBIENT: begin
                  idx_in   = '0;
                  state_in = ST_SWEEP;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SWEEP: begin
            // One cell per cycle: extremes and largest rise against the previous frame.
            if (idx_ff == '0) begin
               hot_in  = cur;
               cold_in = cur;
               rate_in = (!first_ff && (r > 18'sd0)) ? r : 18'sd0;
            end else begin
               hot_in  = (cur > hot_ff) ? cur : hot_ff;
               cold_in = (cur < cold_ff) ? cur : cold_ff;
               rate_in = (!first_ff && (r > rate_ff)) ? r : rate_ff;
            end
            if (idx_ff == LAST_IDX) begin
               for (int i = 0; i < NUM_CELLS; i++) begin
                  prev_in[i] = frame_ff[i];
               end
               first_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (log_start || div_start) begin
         issued_in = 1'b1;
      end
      if (log_done || div_done) begin
         issued_in = 1'b0;
      end

      out_channel_in = out_channel_ff;
      out_temp_in    = out_temp_ff;
      out_fault_in   = out_fault_ff;
      out_done_in    = out_done_ff;
      out_hot_in     = out_hot_ff;
      out_spread_in  = out_spread_ff;
      out_rate_in    = out_rate_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      if (load_out) begin
         out_valid_in   = 1'b1;
         out_channel_in = item_ff.channel[CH_W-1:0];
         out_temp_in    = temp_ff;
         out_fault_in   = fault_ff;
         out_done_in    = (item_ff.kind == KIND_AMBIENT);
         if (item_ff.kind == KIND_AMBIENT) begin
            out_hot_in    = hot_ff;
            out_spread_in = SPREAD_W'(hot_ff - cold_ff);
            out_rate_in   = rate_ff[RATE_W-1:0];
         end else begin
            out_hot_in    = '0;
            out_spread_in = '0;
            out_rate_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
         for (int i = 0; i < NUM_CELLS; i++) begin
            frame_ff[i] <= '0;
            prev_ff[i]  <= PREV_RESET_TEMP;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         out_valid_ff <= out_valid_in;
         first_ff     <= first_in;
         for (int i = 0; i < NUM_CELLS; i++) begin
            frame_ff[i] <= frame_in[i];
            prev_ff[i]  <= prev_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      l_ff           <= l_in;
      p_ff           <= p_in;
      term_ff        <= term_in;
      inv0_ff        <= inv0_in;
      s_ff           <= s_in;
      q_ff           <= q_in;
      kr_ff          <= kr_in;
      ksat_ff        <= ksat_in;
      kneg_ff        <= kneg_in;
      temp_ff        <= temp_in;
      fault_ff       <= fault_in;
      idx_ff         <= idx_in;
      hot_ff         <= hot_in;
      cold_ff        <= cold_in;
      rate_ff        <= rate_in;
      out_channel_ff <= out_channel_in;
      out_temp_ff    <= out_temp_in;
      out_fault_ff   <= out_fault_in;
      out_done_ff    <= out_done_in;
      out_hot_ff     <= out_hot_in;
      out_spread_ff  <= out_spread_in;
      out_rate_ff    <= out_rate_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_out_channel     = out_channel_ff;
   assign rsp_temp_sixteenths = out_temp_ff;
   assign rsp_sensor_fault    = out_fault_ff;
   assign rsp_frame_done      = out_done_ff;
   assign rsp_hottest_cell    = out_hot_ff;
   assign rsp_cell_spread     = out_spread_ff;
   assign rsp_max_rise_rate   = out_rate_ff;

endmodule

// ----- rtl/core/ntc_thermistor_array_monitor_unit.sv -----
// Top level of the thermistor array monitor: configuration registers and the two halves.
//
// Each req_ transaction carries one converter sample, its mux channel and a read-failure
// flag. Channels below NUM_CELLS are cells, channel NUM_CELLS is the ambient sample that
// closes a frame, and every sample gives exactly one rsp_ transaction in input order.
// A frame-closing result also carries the hottest cell, the cell spread and the largest
// rise rate since the previous frame.
// A converted sample passes from acceptance to result through the four-lane log unit,
// three runs on the shared 52-step divider and a reciprocal multiply for the final
// scaling; the converter takes a new sample only once it is through with the last one.
// A faulted sample skips the arithmetic; an ambient sample also walks the stored cell
// temperatures. The csr_ port is always ready; the user must write registers only while
// the block is idle, which the block itself does not enforce.
// Reset restores the register defaults, clears the stored cell temperatures, sets the
// previous-frame temperatures to 25 degC and marks the next frame as the first one.
// When the receiver holds rsp_stall, the result stays in the output register, the
// converter finishes its current sample, and the input queue fills before req_stall rises.
module ntc_thermistor_array_monitor_unit #(
   parameter int ADC_BITS  = ntam_pkg::ADC_BITS_DEF,
   parameter int NUM_CELLS = ntam_pkg::NUM_CELLS_DEF,
   localparam int CH_W     = $clog2(NUM_CELLS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [CH_W-1:0]                       req_channel,
   input  logic [ADC_BITS-1:0]                   req_adc_sample,
   input  logic                                  req_read_failed,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [CH_W-1:0]                       rsp_out_channel,
   output logic signed [ntam_pkg::TEMP_W-1:0]    rsp_temp_sixteenths,
   output logic                                  rsp_sensor_fault,
   output logic                                  rsp_frame_done,
   output logic signed [ntam_pkg::TEMP_W-1:0]    rsp_hottest_cell,
   output logic [ntam_pkg::SPREAD_W-1:0]         rsp_cell_spread,
   output logic [ntam_pkg::RATE_W-1:0]           rsp_max_rise_rate,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ntam_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ntam_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ntam_pkg::*;

   ntam_cfg_type  cfg_ff, cfg_in;
   ntam_item_type item;
   logic          item_valid, item_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (ntam_csr_type'(csr_index))
            CSR_BETA:         cfg_in.beta    = csr_wdata[BETA_W-1:0];
            CSR_SERIES:       cfg_in.series  = csr_wdata[OHMS_W-1:0];
            CSR_NOMINAL_OHMS: cfg_in.nominal = csr_wdata[OHMS_W-1:0];
            CSR_NOMINAL_TEMP: cfg_in.temp0   = csr_wdata[T0_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta    <= BETA_RESET;
         cfg_ff.series  <= SERIES_RESET;
         cfg_ff.nominal <= NOMINAL_RESET;
         cfg_ff.temp0   <= T0_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ntam_front #(
      .ADC_BITS  (ADC_BITS),
      .NUM_CELLS (NUM_CELLS),
      .CH_W      (CH_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_adc_sample  (req_adc_sample),
      .req_read_failed (req_read_failed),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   ntam_back #(
      .ADC_BITS  (ADC_BITS),
      .NUM_CELLS (NUM_CELLS),
      .CH_W      (CH_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_temp_sixteenths (rsp_temp_sixteenths),
      .rsp_sensor_fault    (rsp_sensor_fault),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_hottest_cell    (rsp_hottest_cell),
      .rsp_cell_spread     (rsp_cell_spread),
      .rsp_max_rise_rate   (rsp_max_rise_rate)
   );

endmodule

// ----- rtl/core/ntam_checker.sv -----
// Port-level checks on the monitor's result channel, bound to the top level.
module ntam_checker #(
   parameter int NUM_CELLS = ntam_pkg::NUM_CELLS_DEF,
   parameter int CH_W      = 3
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [CH_W-1:0]                     rsp_out_channel,
   input logic signed [ntam_pkg::TEMP_W-1:0]  rsp_temp_sixteenths,
   input logic                                rsp_sensor_fault,
   input logic                                rsp_frame_done,
   input logic signed [ntam_pkg::TEMP_W-1:0]  rsp_hottest_cell,
   input logic [ntam_pkg::SPREAD_W-1:0]       rsp_cell_spread,
   input logic [ntam_pkg::RATE_W-1:0]         rsp_max_rise_rate
);
   import ntam_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_sixteenths)
                                 && $stable(rsp_out_channel))
      else $error("result changed while stalled");

   a_fault_sentinel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_fault |-> rsp_temp_sixteenths == SENTINEL_TEMP)
      else $error("faulted result without sentinel temperature");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_hottest_cell == '0 && rsp_cell_spread == '0
                                       && rsp_max_rise_rate == '0)
      else $error("summary fields set outside a frame end");

   a_frame_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_channel == CH_W'(NUM_CELLS))
      else $error("frame end reported on a non-ambient channel");

endmodule

bind ntc_thermistor_array_monitor_unit ntam_checker #(
   .NUM_CELLS (NUM_CELLS),
   .CH_W      (CH_W)
) u_ntam_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_channel     (rsp_out_channel),
   .rsp_temp_sixteenths (rsp_temp_sixteenths),
   .rsp_sensor_fault    (rsp_sensor_fault),
   .rsp_frame_done      (rsp_frame_done),
   .rsp_hottest_cell    (rsp_hottest_cell),
   .rsp_cell_spread     (rsp_cell_spread),
   .rsp_max_rise_rate   (rsp_max_rise_rate)
);
